/* rtl/core/shifting_queue_with_remove_at_top_macros.svh */
// Assertion macros shared by the queue modules.
`ifndef SHIFTING_QUEUE_WITH_REMOVE_AT_TOP_MACROS_SVH
`define SHIFTING_QUEUE_WITH_REMOVE_AT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SQRA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication
`define SQRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SQRA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SQRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/sqra_pkg.sv */
package sqra_pkg;

   // Built depth and widths
   localparam int DEPTH  = 16;
   localparam int IDX_W  = 4;
   localparam int CNT_W  = 5;
   localparam int DATA_W = 32;

   // Operation codes
   localparam logic [1:0] MODE_ENQ = 2'd0;
   localparam logic [1:0] MODE_DEQ = 2'd1;
   localparam logic [1:0] MODE_REM = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   localparam logic [DATA_W-1:0] NOTHING_REMOVED = '1;
   localparam logic [CNT_W-1:0]  CAP_RESET       = CNT_W'(DEPTH);

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      logic [1:0]              status;
      logic signed [DATA_W-1:0] newest_value;
      logic [CNT_W-1:0]        entry_count;
      logic                    is_empty;
      logic                    is_full;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } cmd_type;

endpackage

/* rtl/core/sqra_ctrl.sv */
`include "shifting_queue_with_remove_at_top_macros.svh"

module sqra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sqra_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {IDLE, EXEC, LOAD} state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // commands
   assign cmd.capture = req_valid && req_ready_ff;
   assign cmd.exec    = (state_ff == EXEC);
   assign cmd.load    = (state_ff == LOAD) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.capture) state_in = EXEC;
         end
         EXEC: begin
            state_in = LOAD;
         end
         LOAD: begin
            if (out_free) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   assign req_ready_in = (state_in == IDLE);

   // result beat valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // an accepted beat is executed in the next cycle
   `SQRA_ASSERT_NEXT(a_accept_then_exec, clock, reset, req_valid && req_ready_ff, cmd.exec)
   // a load always leaves a valid result beat
   `SQRA_ASSERT_NEXT(a_load_then_valid, clock, reset, cmd.load, rsp_valid_ff)

endmodule

/* rtl/core/sqra_dp.sv */
`include "shifting_queue_with_remove_at_top_macros.svh"

module sqra_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  sqra_pkg::cmd_type             cmd,
   input  sqra_pkg::req_type             req_payload,
   input  logic                          csr_we,
   input  logic [sqra_pkg::CNT_W-1:0]    csr_wdata,
   output sqra_pkg::rsp_type             rsp_payload
);

   localparam int DEPTH  = sqra_pkg::DEPTH;
   localparam int IDX_W  = sqra_pkg::IDX_W;
   localparam int CNT_W  = sqra_pkg::CNT_W;
   localparam int DATA_W = sqra_pkg::DATA_W;

   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [DATA_W-1:0] cells_in [DEPTH];
   logic [DATA_W-1:0] shift_src [DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   sqra_pkg::req_type req_ff, req_in;
   logic [DATA_W-1:0] removed_ff, removed_in;
   logic [1:0]        status_ff, status_in;
   sqra_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0]  eff_cap;
   logic [IDX_W-1:0]  take_idx;
   logic [IDX_W-1:0]  newest_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              do_enq;
   logic              do_take;

   // capacity saturates at the built depth
   assign eff_cap = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;

   // single read port over the cells: take slot while executing, newest slot on load
   assign take_idx    = (req_ff.mode == sqra_pkg::MODE_DEQ) ? '0 : req_ff.position;
   assign newest_addr = IDX_W'(count_ff - CNT_W'(1));
   assign rd_addr     = cmd.exec ? take_idx : newest_addr;
   assign rd_data     = cells_ff[rd_addr];

   // operation decode and status
   always_comb begin
      do_enq    = 1'b0;
      do_take   = 1'b0;
      status_in = sqra_pkg::ST_OK;
      case (req_ff.mode)
         sqra_pkg::MODE_ENQ: begin
            if (count_ff < eff_cap) do_enq = 1'b1;
            else status_in = sqra_pkg::ST_FULL;
         end
         sqra_pkg::MODE_DEQ: begin
            if (count_ff != '0) do_take = 1'b1;
            else status_in = sqra_pkg::ST_EMPTY;
         end
         sqra_pkg::MODE_REM: begin
            if ({1'b0, req_ff.position} < count_ff) do_take = 1'b1;
            else status_in = sqra_pkg::ST_BADPOS;
         end
         default: begin
            status_in = sqra_pkg::ST_OK;
         end
      endcase
   end

   assign removed_in = do_take ? rd_data : sqra_pkg::NOTHING_REMOVED;

   // each cell's upper neighbor; the top cell keeps its own value
   for (genvar g = 0; g < DEPTH; g++) begin : g_src
      if (g < DEPTH - 1) begin : g_mid
         assign shift_src[g] = cells_ff[g + 1];
      end else begin : g_top
         assign shift_src[g] = cells_ff[g];
      end
   end

   // all cells update together: append at count, or close the gap above the taken slot
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.exec && do_enq && (CNT_W'(i) == count_ff))
            cells_in[i] = req_ff.value;
         if (cmd.exec && do_take && (CNT_W'(i) >= {1'b0, take_idx}))
            cells_in[i] = shift_src[i];
      end
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (cmd.exec && do_enq)  count_in = count_ff + CNT_W'(1);
      if (cmd.exec && do_take) count_in = count_ff - CNT_W'(1);
   end

   assign cap_in = csr_we ? csr_wdata : cap_ff;
   assign req_in = cmd.capture ? req_payload : req_ff;

   // result beat, built after the count has settled
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.removed_value = removed_ff;
      rsp_in.status        = status_ff;
      rsp_in.newest_value  = (count_ff == '0) ? '0 : rd_data;
      rsp_in.entry_count   = count_ff;
      rsp_in.is_empty      = (count_ff == '0);
      rsp_in.is_full       = (count_ff >= eff_cap);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= sqra_pkg::CAP_RESET;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      req_ff   <= req_in;
      if (cmd.exec) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
      if (cmd.load) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   // count never exceeds the built depth
   `SQRA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   // a successful append grows the count by one
   `SQRA_ASSERT_NEXT(a_enq_grows, clock, reset, cmd.exec && do_enq, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

/* rtl/core/shifting_queue_with_remove_at_top.sv */
// Channel   Ports                           Direction   Content
// req       req_valid/req_ready/req_payload in          mode, value, position
// rsp       rsp_valid/rsp_ready/rsp_payload out         one result beat per request
// csr       csr_we/csr_wdata                in          capacity, write only
//
// A request goes through accept, execute (one read through the cell
// read mux, then all cells shift or append together), and load of the result
// beat with the newest entry read through the same mux.
// A new request is accepted while a finished beat waits in the output register;
// the load step holds until that register is free.
// Reset is synchronous: count is zero, capacity is 16, no beat pending.
module shifting_queue_with_remove_at_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sqra_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sqra_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [sqra_pkg::CNT_W-1:0]    csr_wdata
);

   sqra_pkg::cmd_type cmd;

   // sequencer
   sqra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // cells, count, capacity and result register
   sqra_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

/* test/tb_shifting_queue_with_remove_at_top.sv */
`timescale 1ns / 100ps

module tb_shifting_queue_with_remove_at_top;

   localparam int DEPTH  = sqra_pkg::DEPTH;
   localparam int IDX_W  = sqra_pkg::IDX_W;
   localparam int CNT_W  = sqra_pkg::CNT_W;
   localparam int DATA_W = sqra_pkg::DATA_W;

   // Mode 3 has no operation; the queue must report it as a plain ok
   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_OPS   = 183;
   localparam int HOLD_CYCLES = 80;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   sqra_pkg::req_type   req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   sqra_pkg::rsp_type   rsp_payload;
   logic                csr_we      = 1'b0;
   logic [CNT_W-1:0]    csr_wdata   = '0;

   // Operations waiting to be offered, results waiting to come back
   sqra_pkg::req_type queued_ops [$];
   sqra_pkg::rsp_type queue_results_due [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  req_took, rsp_took;
   bit  steady_flow    = 1'b0;   // no random gaps on either side, after the receiver's hold-off
   bit  steady_seen    = 1'b0;
   int  enq_pct        = 50;
   int  send_wait      = 0;
   int  recv_wait      = 0;
   int  recv_hold      = 0;      // long receiver stall, counted by the receiver

   // Shadow copy of the queue contents and capacity register
   logic signed [DATA_W-1:0] shadow_slots [DEPTH];
   int                       shadow_count;
   logic [CNT_W-1:0]         shadow_cap;

   shifting_queue_with_remove_at_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // Apply one operation to the shadow queue and build the result beat
   function automatic sqra_pkg::rsp_type predict_queue_op(sqra_pkg::req_type op);
      sqra_pkg::rsp_type r;
      int                room;
      int                idx;
      bit                take;
      r.removed_value = sqra_pkg::NOTHING_REMOVED;
      r.status        = sqra_pkg::ST_OK;
      room = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
      take = 1'b0;
      idx  = 0;
      case (op.mode)
         sqra_pkg::MODE_ENQ: begin
            if (shadow_count >= room) begin
               r.status = sqra_pkg::ST_FULL;
            end else begin
               shadow_slots[IDX_W'(shadow_count)] = op.value;
               shadow_count++;
            end
         end
         sqra_pkg::MODE_DEQ: begin
            if (shadow_count == 0) r.status = sqra_pkg::ST_EMPTY;
            else take = 1'b1;
         end
         sqra_pkg::MODE_REM: begin
            if (int'(op.position) >= shadow_count) begin
               r.status = sqra_pkg::ST_BADPOS;
            end else begin
               take = 1'b1;
               idx  = int'(op.position);
            end
         end
         default: ;
      endcase
      // take the entry and close the gap
      if (take) begin
         r.removed_value = shadow_slots[IDX_W'(idx)];
         for (int i = idx; i + 1 < shadow_count; i++)
            shadow_slots[IDX_W'(i)] = shadow_slots[IDX_W'(i + 1)];
         shadow_count--;
      end
      if (shadow_count > 0) r.newest_value = shadow_slots[IDX_W'(shadow_count - 1)];
      else r.newest_value = '0;
      r.entry_count  = CNT_W'(shadow_count);
      r.is_empty     = (shadow_count == 0);
      r.is_full      = (shadow_count >= room);
      return r;
   endfunction

   function automatic sqra_pkg::req_type random_op();
      sqra_pkg::req_type op;
      int                roll;
      roll     = $urandom_range(0, 99);
      op.value = $urandom();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0:       op.value = 32'h7fffffff;
            1:       op.value = 32'h80000000;
            2:       op.value = '1;
            default: op.value = '0;
         endcase
      end
      op.position = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3))
                                         : IDX_W'($urandom_range(0, 15));
      if (roll < enq_pct)     op.mode = sqra_pkg::MODE_ENQ;
      else if (roll >= 98)    op.mode = MODE_NOP;
      else if (roll % 2 == 1) op.mode = sqra_pkg::MODE_DEQ;
      else                    op.mode = sqra_pkg::MODE_REM;
      return op;
   endfunction

   task automatic push_op(logic [1:0] m, logic [DATA_W-1:0] v, logic [IDX_W-1:0] p);
      sqra_pkg::req_type op;
      op.mode     = m;
      op.value    = v;
      op.position = p;
      queued_ops.push_back(op);
   endtask

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected %h, got %h", $time, what, want, got);
   endtask

   // Wait until every operation is offered and answered, then let the block settle
   task automatic wait_idle();
      while (queued_ops.size() != 0 || req_valid || queue_results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CNT_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Request driver: holds each beat until taken, then waits its drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_took) send_wait = steady_flow ? 0 : $urandom_range(0, 6);
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait--;
         end else if (queued_ops.size() != 0) begin
            req_payload <= queued_ops.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls per beat, plus a long hold-off when steady flow starts
   always @(negedge clock) begin
      if (steady_flow && !steady_seen) recv_hold = HOLD_CYCLES;
      steady_seen = steady_flow;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         rsp_ready <= 1'b0;
         recv_hold--;
      end else begin
         if (rsp_took) recv_wait = steady_flow ? 0 : $urandom_range(0, 6);
         if (recv_wait > 0) begin
            rsp_ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check result beats, predict accepted requests, track csr writes
   always @(posedge clock) begin
      sqra_pkg::rsp_type seen;
      sqra_pkg::rsp_type want;
      req_took = !reset && req_valid && req_ready;
      rsp_took = !reset && rsp_valid && rsp_ready;
      if (reset) begin
         shadow_count = 0;
         shadow_cap   = sqra_pkg::CAP_RESET;
         queue_results_due.delete();
      end else begin
         if (rsp_took) begin
            seen = rsp_payload;
            if (queue_results_due.size() == 0) begin
               report_mismatch("result beat with nothing expected", '0, seen.removed_value);
            end else begin
               want = queue_results_due.pop_front();
               if (seen.removed_value !== want.removed_value)
                  report_mismatch("removed_value", want.removed_value, seen.removed_value);
               if (seen.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(seen.status));
               if (seen.newest_value !== want.newest_value)
                  report_mismatch("newest_value", want.newest_value, seen.newest_value);
               if (seen.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(want.entry_count),
                                  32'(seen.entry_count));
               if (seen.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(want.is_empty), 32'(seen.is_empty));
               if (seen.is_full !== want.is_full)
                  report_mismatch("is_full", 32'(want.is_full), 32'(seen.is_full));
            end
         end
         if (req_took) queue_results_due.push_back(predict_queue_op(req_payload));
         if (csr_we) shadow_cap = csr_wdata;
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Stimulus sequence
   initial begin
      logic [CNT_W-1:0] phase_caps [8] = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd8, 5'd17, 5'd3, 5'd16};
      logic [CNT_W-1:0] cap;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset capacity: empty cases, value extremes, bad and good positions
      push_op(sqra_pkg::MODE_DEQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_REM, $urandom(), 4'd0);
      push_op(MODE_NOP, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, 32'h7fffffff, IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, 32'h80000000, IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, 32'h00000000, IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, 32'hffffffff, IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_REM, $urandom(), 4'd4);
      push_op(sqra_pkg::MODE_REM, $urandom(), 4'd15);
      push_op(sqra_pkg::MODE_REM, $urandom(), 4'd1);
      push_op(sqra_pkg::MODE_DEQ, $urandom(), IDX_W'($urandom()));
      push_op(MODE_NOP, $urandom(), IDX_W'($urandom()));
      wait_idle();

      // capacity lowered below the count
      set_capacity(5'd1);
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_REM, $urandom(), 4'd1);
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_DEQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      wait_idle();

      // zero capacity: empty and full at once
      set_capacity(5'd0);
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_DEQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_ENQ, $urandom(), IDX_W'($urandom()));
      push_op(sqra_pkg::MODE_DEQ, $urandom(), IDX_W'($urandom()));
      wait_idle();

      // random phases over several capacities
      for (int p = 0; p < 10; p++) begin
         cap = (p < 8) ? phase_caps[3'(p)] : CNT_W'($urandom_range(0, 31));
         set_capacity(cap);
         enq_pct     = (p % 3 == 0) ? 75 : (p % 3 == 1) ? 35 : 55;
         steady_flow = (p == 2 || p == 6);
         for (int n = 0; n < PHASE_OPS; n++)
            queued_ops.push_back(random_op());
         wait_idle();
      end

      steady_flow = 1'b0;
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
